>>> rtl/rpnv_pkg.sv
// ----------------------------------------------------------------------------
// Relative path name validator package
// Shared types, status codes and constants of the path name validator.
// ----------------------------------------------------------------------------
package rpnv_pkg;

  localparam int MAX_PATH_BYTES = 4096;
  localparam int NAME_LIMIT     = 255;
  localparam int CNT_W          = $clog2(MAX_PATH_BYTES + 1);

  localparam logic [7:0] CTRL_LIMIT = 8'h20;
  localparam logic [7:0] CHR_DEL    = 8'h7F;
  localparam logic [7:0] CHR_SLASH  = 8'h2F;
  localparam logic [7:0] CHR_BSLASH = 8'h5C;
  localparam logic [7:0] CHR_COLON  = 8'h3A;
  localparam logic [7:0] CHR_STAR   = 8'h2A;
  localparam logic [7:0] CHR_QUERY  = 8'h3F;
  localparam logic [7:0] CHR_DOT    = 8'h2E;
  localparam logic [7:0] CHR_SPACE  = 8'h20;
  localparam logic [7:0] CHR_LOW_A  = 8'h61;
  localparam logic [7:0] CHR_LOW_Z  = 8'h7A;
  localparam logic [7:0] CHR_ONE    = 8'h31;
  localparam logic [7:0] CHR_NINE   = 8'h39;

  // Device stems, first byte in the lowest position.
  localparam logic [23:0] STEM_CON = 24'h4E4F43;
  localparam logic [23:0] STEM_PRN = 24'h4E5250;
  localparam logic [23:0] STEM_AUX = 24'h585541;
  localparam logic [23:0] STEM_NUL = 24'h4C554E;
  localparam logic [23:0] STEM_COM = 24'h4D4F43;
  localparam logic [23:0] STEM_LPT = 24'h54504C;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_EMPTY    = 4'd1,
    ST_DOT      = 4'd2,
    ST_SEP      = 4'd3,
    ST_COLON    = 4'd4,
    ST_WILD     = 4'd5,
    ST_CTRL     = 4'd6,
    ST_RESERVED = 4'd7,
    ST_TRAIL    = 4'd8,
    ST_LONG     = 4'd9
  } status_t;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       end_of_path;
  } in_item_t;

  typedef struct packed {
    logic [3:0]       status;
    logic [CNT_W-1:0] bad_offset;
    logic [CNT_W-1:0] bad_length;
  } out_item_t;

  typedef struct packed {
    logic [CNT_W-1:0] length;
    logic [2:0]       first_err;
    logic [7:0]       prev_byte;
    logic             only_dots;
    logic [31:0]      stem;
    logic [2:0]       stem_len;
    logic             stem_closed;
  } seg_t;

  localparam seg_t SEG_CLEAR = '{
    length: '0, first_err: '0, prev_byte: '0, only_dots: 1'b1,
    stem: '0, stem_len: '0, stem_closed: 1'b0
  };

  function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
    sat_inc = (v == CNT_W'(MAX_PATH_BYTES)) ? v : v + CNT_W'(1);
  endfunction

endpackage

>>> rtl/rpnv_judge.sv
// ----------------------------------------------------------------------------
// Path component judge
// Gives the status of one finished path component from its running summary.
// ----------------------------------------------------------------------------
module rpnv_judge (
  input  rpnv_pkg::seg_t    seg,
  output rpnv_pkg::status_t status
);

  logic stem3_rsv;
  logic stem4_rsv;
  logic digit_ok;

  assign digit_ok  = (seg.stem[31:24] >= rpnv_pkg::CHR_ONE) &&
                     (seg.stem[31:24] <= rpnv_pkg::CHR_NINE);
  assign stem3_rsv = (seg.stem_len == 3'd3) &&
                     ((seg.stem[23:0] == rpnv_pkg::STEM_CON) ||
                      (seg.stem[23:0] == rpnv_pkg::STEM_PRN) ||
                      (seg.stem[23:0] == rpnv_pkg::STEM_AUX) ||
                      (seg.stem[23:0] == rpnv_pkg::STEM_NUL));
  assign stem4_rsv = (seg.stem_len == 3'd4) && digit_ok &&
                     ((seg.stem[23:0] == rpnv_pkg::STEM_COM) ||
                      (seg.stem[23:0] == rpnv_pkg::STEM_LPT));

  always_comb begin
    if (seg.length == '0) begin
      status = rpnv_pkg::ST_EMPTY;
    end else if (seg.only_dots && (seg.length <= rpnv_pkg::CNT_W'(2))) begin
      status = rpnv_pkg::ST_DOT;
    end else if (seg.length > rpnv_pkg::CNT_W'(rpnv_pkg::NAME_LIMIT)) begin
      status = rpnv_pkg::ST_LONG;
    end else if (seg.first_err != 3'd0) begin
      status = rpnv_pkg::status_t'({1'b0, seg.first_err});
    end else if ((seg.prev_byte == rpnv_pkg::CHR_DOT) ||
                 (seg.prev_byte == rpnv_pkg::CHR_SPACE)) begin
      status = rpnv_pkg::ST_TRAIL;
    end else if (stem3_rsv || stem4_rsv) begin
      status = rpnv_pkg::ST_RESERVED;
    end else begin
      status = rpnv_pkg::ST_OK;
    end
  end

endmodule

>>> rtl/relative_path_name_validator.sv
// ----------------------------------------------------------------------------
// Relative path name validator
// Checks a relative path, one byte per request, and gives one verdict per path.
// ----------------------------------------------------------------------------
// The verdict is registered and appears in the cycle after the end request is accepted.
// Throughput: one request per cycle while in_stall is low; the path state updates on every accepted request.
// Input stalls only while a registered verdict is held by a stalled output.
// Reset: synchronous, active low; clears the path state and the output valid.
module relative_path_name_validator (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  rpnv_pkg::in_item_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output rpnv_pkg::out_item_t out_data
);

  localparam int CW = rpnv_pkg::CNT_W;

  logic [CW-1:0]        pos_r, pos_nxt;
  logic [CW-1:0]        seg_start_r, seg_start_nxt;
  rpnv_pkg::seg_t       seg_r, seg_nxt;
  logic                 found_r, found_nxt;
  rpnv_pkg::status_t    v_status_r, v_status_nxt;
  logic [CW-1:0]        v_off_r, v_off_nxt;
  logic [CW-1:0]        v_len_r, v_len_nxt;
  logic                 abs_r, abs_nxt;
  logic                 out_valid_r, out_valid_nxt;
  rpnv_pkg::out_item_t  out_data_r, out_data_nxt;
  rpnv_pkg::status_t    seg_status;
  logic                 accept;
  logic [7:0]           c;
  logic [7:0]           c_up;

  rpnv_judge u_judge (
    .seg    (seg_r),
    .status (seg_status)
  );

  assign in_stall  = out_valid_r && out_stall;
  assign accept    = in_valid && !in_stall;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;
  assign c         = in_data.data_byte;
  assign c_up      = ((c >= rpnv_pkg::CHR_LOW_A) && (c <= rpnv_pkg::CHR_LOW_Z)) ?
                     (c - 8'h20) : c;

  always_comb begin
    pos_nxt       = pos_r;
    seg_start_nxt = seg_start_r;
    seg_nxt       = seg_r;
    found_nxt     = found_r;
    v_status_nxt  = v_status_r;
    v_off_nxt     = v_off_r;
    v_len_nxt     = v_len_r;
    abs_nxt       = abs_r;
    out_data_nxt  = out_data_r;
    out_valid_nxt = out_valid_r && out_stall;

    if (accept && in_data.end_of_path) begin
      out_valid_nxt = 1'b1;
      if (abs_r) begin
        out_data_nxt.status     = rpnv_pkg::ST_SEP;
        out_data_nxt.bad_offset = '0;
        out_data_nxt.bad_length = pos_r;
      end else if (found_r) begin
        out_data_nxt.status     = v_status_r;
        out_data_nxt.bad_offset = v_off_r;
        out_data_nxt.bad_length = v_len_r;
      end else if (seg_status != rpnv_pkg::ST_OK) begin
        out_data_nxt.status     = seg_status;
        out_data_nxt.bad_offset = seg_start_r;
        out_data_nxt.bad_length = seg_r.length;
      end else begin
        out_data_nxt.status     = rpnv_pkg::ST_OK;
        out_data_nxt.bad_offset = '0;
        out_data_nxt.bad_length = '0;
      end
      pos_nxt       = '0;
      seg_start_nxt = '0;
      seg_nxt       = rpnv_pkg::SEG_CLEAR;
      found_nxt     = 1'b0;
      v_status_nxt  = rpnv_pkg::ST_OK;
      v_off_nxt     = '0;
      v_len_nxt     = '0;
      abs_nxt       = 1'b0;
    end else if (accept) begin
      if (!abs_r && !found_r) begin
        if ((pos_r == '0) &&
            ((c == rpnv_pkg::CHR_SLASH) || (c == rpnv_pkg::CHR_BSLASH))) begin
          abs_nxt = 1'b1;
        end else if (c == rpnv_pkg::CHR_SLASH) begin
          if (seg_status != rpnv_pkg::ST_OK) begin
            found_nxt    = 1'b1;
            v_status_nxt = seg_status;
            v_off_nxt    = seg_start_r;
            v_len_nxt    = seg_r.length;
          end
          seg_nxt       = rpnv_pkg::SEG_CLEAR;
          seg_start_nxt = rpnv_pkg::sat_inc(pos_r);
        end else begin
          seg_nxt.length = rpnv_pkg::sat_inc(seg_r.length);
          if (seg_r.first_err == 3'd0) begin
            if ((c < rpnv_pkg::CTRL_LIMIT) || (c == rpnv_pkg::CHR_DEL)) begin
              seg_nxt.first_err = 3'(rpnv_pkg::ST_CTRL);
            end else if (c == rpnv_pkg::CHR_BSLASH) begin
              seg_nxt.first_err = 3'(rpnv_pkg::ST_SEP);
            end else if (c == rpnv_pkg::CHR_COLON) begin
              seg_nxt.first_err = 3'(rpnv_pkg::ST_COLON);
            end else if ((c == rpnv_pkg::CHR_STAR) || (c == rpnv_pkg::CHR_QUERY)) begin
              seg_nxt.first_err = 3'(rpnv_pkg::ST_WILD);
            end
          end
          seg_nxt.prev_byte = c;
          if (c != rpnv_pkg::CHR_DOT) begin
            seg_nxt.only_dots = 1'b0;
          end
          if (!seg_r.stem_closed) begin
            if (c == rpnv_pkg::CHR_DOT) begin
              seg_nxt.stem_closed = 1'b1;
            end else begin
              if (seg_r.stem_len < 3'd4) begin
                seg_nxt.stem[{seg_r.stem_len[1:0], 3'b000} +: 8] = c_up;
              end
              if (seg_r.stem_len < 3'd5) begin
                seg_nxt.stem_len = seg_r.stem_len + 3'd1;
              end
            end
          end
        end
      end
      pos_nxt = rpnv_pkg::sat_inc(pos_r);
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r       <= '0;
      seg_start_r <= '0;
      seg_r       <= rpnv_pkg::SEG_CLEAR;
      found_r     <= 1'b0;
      v_status_r  <= rpnv_pkg::ST_OK;
      v_off_r     <= '0;
      v_len_r     <= '0;
      abs_r       <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      pos_r       <= pos_nxt;
      seg_start_r <= seg_start_nxt;
      seg_r       <= seg_nxt;
      found_r     <= found_nxt;
      v_status_r  <= v_status_nxt;
      v_off_r     <= v_off_nxt;
      v_len_r     <= v_len_nxt;
      abs_r       <= abs_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_data_r <= out_data_nxt;
  end

endmodule
